// ===== rtl/core/jlvp_pkg.sv =====
// jlvp_pkg: shared types, codes and the step program of the velocity planner
// used by jlvp_ctrl, jlvp_dp and the top level; depends on nothing else
package jlvp_pkg;

  localparam int PC_W = 6;
  localparam logic [PC_W-1:0] LAST_PC = 6'd52;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_W = 31;

  localparam logic [CFG_W-1:0] SPEED_LIMIT_RST = 31'd6553600;
  localparam logic [CFG_W-1:0] ACCEL_LIMIT_RST = 31'd13107200;
  localparam logic [CFG_W-1:0] JERK_LIMIT_RST  = 31'd131072000;
  localparam logic [CFG_W-1:0] STEP_TIME_RST   = 31'd328;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SPEED_LIMIT,
    CFG_ACCEL_LIMIT,
    CFG_JERK_LIMIT,
    CFG_STEP_TIME
  } cfg_idx_t;

  typedef enum logic [4:0] {
    R_OX, R_OY, R_DIST, R_T1, R_T2, R_SAFE, R_TGT, R_IVX, R_IVY, R_RX, R_RY,
    R_DJX, R_DJY, R_SC, R_AX, R_AY, R_VX, R_VY, R_VMAX, R_AMAX, R_JMAX, R_DT
  } reg_sel_t;

  typedef enum logic [4:0] {
    UO_PSET, UO_PADD, UO_PDBL, UO_PSHL, UO_SQRT, UO_SQRTH, UO_MUL, UO_DIV,
    UO_SUB, UO_SUBZ, UO_ADD, UO_HALF, UO_MIN, UO_SNAP, UO_ZERO, UO_MOV,
    UO_CLR, UO_OUT
  } uop_t;

  typedef enum logic [2:0] {
    C_ALL, C_SAFE_HI, C_SAFE_LO, C_NEAR_HI, C_NEAR_LO, C_DJ_HI, C_DJ_LO, C_AM_HI
  } cond_t;

  typedef struct packed {
    cond_t    cond;
    uop_t     op;
    reg_sel_t a;
    reg_sel_t b;
    reg_sel_t d;
  } uinstr_t;

  typedef struct packed {
    logic     load;
    logic     go;
    uop_t     op;
    reg_sel_t a;
    reg_sel_t b;
    reg_sel_t d;
  } cmd_t;

  typedef struct packed {
    logic done;
    logic safe_hi;
    logic dist_hi;
    logic dj_hi;
    logic am_hi;
  } stat_t;

  function automatic uinstr_t ui(input cond_t c, input uop_t o, input reg_sel_t a,
                                 input reg_sel_t b, input reg_sel_t d);
    uinstr_t r;
    r.cond = c;
    r.op   = o;
    r.a    = a;
    r.b    = b;
    r.d    = d;
    return r;
  endfunction

  // one line of the plan step program; skipped lines are the untaken side of a branch
  function automatic uinstr_t ucode(input logic [PC_W-1:0] pc);
    uinstr_t r;
    case (pc)
      6'd0:  r = ui(C_ALL,     UO_PSET,  R_OX,   R_OX,   R_T1);
      6'd1:  r = ui(C_ALL,     UO_PADD,  R_OY,   R_OY,   R_T1);
      6'd2:  r = ui(C_ALL,     UO_SQRT,  R_T1,   R_T1,   R_DIST);
      6'd3:  r = ui(C_ALL,     UO_PSET,  R_VX,   R_VX,   R_T1);
      6'd4:  r = ui(C_ALL,     UO_PADD,  R_VY,   R_VY,   R_T1);
      6'd5:  r = ui(C_ALL,     UO_SQRT,  R_T1,   R_T1,   R_T1);
      6'd6:  r = ui(C_ALL,     UO_DIV,   R_AMAX, R_JMAX, R_T2);
      6'd7:  r = ui(C_ALL,     UO_MUL,   R_T1,   R_T2,   R_T1);
      6'd8:  r = ui(C_ALL,     UO_HALF,  R_T1,   R_T1,   R_T1);
      6'd9:  r = ui(C_ALL,     UO_SUBZ,  R_DIST, R_T1,   R_SAFE);
      6'd10: r = ui(C_SAFE_HI, UO_PDBL,  R_AMAX, R_SAFE, R_T1);
      6'd11: r = ui(C_SAFE_HI, UO_SQRT,  R_T1,   R_T1,   R_TGT);
      6'd12: r = ui(C_SAFE_LO, UO_PSHL,  R_AMAX, R_AMAX, R_T1);
      6'd13: r = ui(C_SAFE_LO, UO_SQRTH, R_T1,   R_T1,   R_T1);
      6'd14: r = ui(C_SAFE_LO, UO_MUL,   R_T1,   R_SAFE, R_TGT);
      6'd15: r = ui(C_ALL,     UO_MIN,   R_TGT,  R_VMAX, R_TGT);
      6'd16: r = ui(C_ALL,     UO_SNAP,  R_TGT,  R_TGT,  R_TGT);
      6'd17: r = ui(C_NEAR_LO, UO_ZERO,  R_T1,   R_T1,   R_IVX);
      6'd18: r = ui(C_NEAR_LO, UO_ZERO,  R_T1,   R_T1,   R_IVY);
      6'd19: r = ui(C_NEAR_HI, UO_DIV,   R_OX,   R_DIST, R_T1);
      6'd20: r = ui(C_NEAR_HI, UO_MUL,   R_TGT,  R_T1,   R_IVX);
      6'd21: r = ui(C_NEAR_HI, UO_DIV,   R_OY,   R_DIST, R_T1);
      6'd22: r = ui(C_NEAR_HI, UO_MUL,   R_TGT,  R_T1,   R_IVY);
      6'd23: r = ui(C_ALL,     UO_SUB,   R_IVX,  R_VX,   R_T1);
      6'd24: r = ui(C_ALL,     UO_DIV,   R_T1,   R_DT,   R_RX);
      6'd25: r = ui(C_ALL,     UO_SUB,   R_IVY,  R_VY,   R_T1);
      6'd26: r = ui(C_ALL,     UO_DIV,   R_T1,   R_DT,   R_RY);
      6'd27: r = ui(C_ALL,     UO_SUB,   R_RX,   R_AX,   R_DJX);
      6'd28: r = ui(C_ALL,     UO_SUB,   R_RY,   R_AY,   R_DJY);
      6'd29: r = ui(C_ALL,     UO_PSET,  R_DJX,  R_DJX,  R_T1);
      6'd30: r = ui(C_ALL,     UO_PADD,  R_DJY,  R_DJY,  R_T1);
      6'd31: r = ui(C_ALL,     UO_SQRT,  R_T1,   R_T1,   R_T1);
      6'd32: r = ui(C_ALL,     UO_MUL,   R_JMAX, R_DT,   R_T2);
      6'd33: r = ui(C_DJ_HI,   UO_DIV,   R_T2,   R_T1,   R_SC);
      6'd34: r = ui(C_DJ_HI,   UO_MUL,   R_DJX,  R_SC,   R_DJX);
      6'd35: r = ui(C_DJ_HI,   UO_ADD,   R_AX,   R_DJX,  R_AX);
      6'd36: r = ui(C_DJ_HI,   UO_MUL,   R_DJY,  R_SC,   R_DJY);
      6'd37: r = ui(C_DJ_HI,   UO_ADD,   R_AY,   R_DJY,  R_AY);
      6'd38: r = ui(C_DJ_LO,   UO_MOV,   R_RX,   R_RX,   R_AX);
      6'd39: r = ui(C_DJ_LO,   UO_MOV,   R_RY,   R_RY,   R_AY);
      6'd40: r = ui(C_ALL,     UO_PSET,  R_AX,   R_AX,   R_T1);
      6'd41: r = ui(C_ALL,     UO_PADD,  R_AY,   R_AY,   R_T1);
      6'd42: r = ui(C_ALL,     UO_SQRT,  R_T1,   R_T1,   R_T1);
      6'd43: r = ui(C_AM_HI,   UO_DIV,   R_AMAX, R_T1,   R_SC);
      6'd44: r = ui(C_AM_HI,   UO_MUL,   R_AX,   R_SC,   R_AX);
      6'd45: r = ui(C_AM_HI,   UO_MUL,   R_AY,   R_SC,   R_AY);
      6'd46: r = ui(C_ALL,     UO_MUL,   R_AX,   R_DT,   R_T1);
      6'd47: r = ui(C_ALL,     UO_ADD,   R_VX,   R_T1,   R_VX);
      6'd48: r = ui(C_ALL,     UO_MUL,   R_AY,   R_DT,   R_T1);
      6'd49: r = ui(C_ALL,     UO_ADD,   R_VY,   R_T1,   R_VY);
      6'd50: r = ui(C_ALL,     UO_PSET,  R_VX,   R_VX,   R_T1);
      6'd51: r = ui(C_ALL,     UO_PADD,  R_VY,   R_VY,   R_T1);
      6'd52: r = ui(C_ALL,     UO_SQRT,  R_T1,   R_T1,   R_T1);
      default: r = ui(C_ALL,   UO_MOV,   R_T1,   R_T1,   R_T1);
    endcase
    return r;
  endfunction

endpackage

// ===== rtl/core/jlvp_dp.sv =====
// jlvp_dp: planner datapath with working registers, config registers and
// shared bit-serial multiply, divide and square-root units; uses jlvp_pkg
module jlvp_dp #(
  parameter int FRAC_BITS = 16,
  parameter int WORD_BITS = 32
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  cfg_we,
  input  logic [jlvp_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [jlvp_pkg::CFG_W-1:0]            cfg_data,
  input  logic signed [31:0]                    in_x,
  input  logic signed [31:0]                    in_y,
  input  jlvp_pkg::cmd_t                        cmd,
  output jlvp_pkg::stat_t                       stat,
  output logic signed [31:0]                    out_vx,
  output logic signed [31:0]                    out_vy,
  output logic [30:0]                           out_speed
);

  localparam int W  = WORD_BITS;
  localparam int F  = FRAC_BITS;
  localparam int QW = 2 * W;
  localparam int AW = 2 * W + 2;
  localparam int RW = W + 1;
  localparam int DW = W + F;
  localparam int CW = $clog2(DW + 1);

  localparam logic signed [W-1:0] WMAX = {1'b0, {(W-1){1'b1}}};
  localparam logic signed [W-1:0] WMIN = {1'b1, {(W-1){1'b0}}};
  localparam logic signed [63:0] WMAX64 = (64'sd1 <<< (W - 1)) - 64'sd1;
  localparam logic signed [63:0] WMIN64 = -WMAX64 - 64'sd1;
  localparam logic [63:0] TENTH64 = ((64'd1 << F) + 64'd5) / 64'd10;
  localparam logic [63:0] HALF64  = 64'd1 << (F - 1);
  localparam logic [63:0] TWO64   = 64'd1 << (F + 1);
  localparam logic signed [W-1:0] TENTH = TENTH64[W-1:0];
  localparam logic signed [W-1:0] HALF  = HALF64[W-1:0];
  localparam logic signed [W-1:0] TWO   = TWO64[W-1:0];
  localparam logic [QW-1:0] QLIM = QW'(1) << (W - 1);

  function automatic logic signed [W-1:0] sat64(input logic signed [63:0] v);
    if (v > WMAX64) begin
      return WMAX;
    end else if (v < WMIN64) begin
      return WMIN;
    end
    return v[W-1:0];
  endfunction

  function automatic logic signed [W-1:0] satw1(input logic signed [W:0] v);
    if (v[W] != v[W-1]) begin
      return v[W] ? WMIN : WMAX;
    end
    return v[W-1:0];
  endfunction

  // magnitude plus sign back to a saturated word
  function automatic logic signed [W-1:0] wsigned(input logic [QW-1:0] m, input logic neg);
    logic [QW-1:0] lim;
    lim = neg ? QLIM : QLIM - QW'(1);
    if (m > lim) begin
      return neg ? WMIN : WMAX;
    end
    return neg ? -m[W-1:0] : m[W-1:0];
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [W-1:0] v);
    logic signed [63:0] e;
    e = 64'(v);
    if (e > 64'sd2147483647) begin
      return 32'sh7fffffff;
    end else if (e < -64'sd2147483648) begin
      return 32'sh80000000;
    end
    return e[31:0];
  endfunction

  logic signed [W-1:0] ox, oy, distance, t1, t2, safe, tgt, ivx, ivy, rx, ry;
  logic signed [W-1:0] djx, djy, sc, ax, ay, vx, vy;
  logic [jlvp_pkg::CFG_W-1:0] cfg_speed, cfg_accel, cfg_jerk, cfg_dt;
  logic signed [W-1:0] vmax, amax, jmax, dt;

  logic [AW-1:0]     acc;
  logic [QW-1:0]     prod, mcand;
  logic [W-1:0]      mplier;
  logic [W:0]        rem;
  logic [W-1:0]      dvs;
  logic [DW-1:0]     dq;
  logic [AW-1:0]     sacc;
  logic [RW-1:0]     root;
  logic [RW+1:0]     srem;
  logic              run, done, neg_q, sa_q, dz_q;
  logic [CW-1:0]     cnt;
  jlvp_pkg::uop_t     op_q;
  jlvp_pkg::reg_sel_t d_q;

  assign vmax = sat64(64'(cfg_speed));
  assign amax = sat64(64'(cfg_accel));
  assign jmax = sat64(64'(cfg_jerk));
  assign dt   = sat64(64'(cfg_dt));

  function automatic logic signed [W-1:0] rd(input jlvp_pkg::reg_sel_t r);
    logic signed [W-1:0] v;
    unique case (r)
      jlvp_pkg::R_OX:   v = ox;
      jlvp_pkg::R_OY:   v = oy;
      jlvp_pkg::R_DIST: v = distance;
      jlvp_pkg::R_T1:   v = t1;
      jlvp_pkg::R_T2:   v = t2;
      jlvp_pkg::R_SAFE: v = safe;
      jlvp_pkg::R_TGT:  v = tgt;
      jlvp_pkg::R_IVX:  v = ivx;
      jlvp_pkg::R_IVY:  v = ivy;
      jlvp_pkg::R_RX:   v = rx;
      jlvp_pkg::R_RY:   v = ry;
      jlvp_pkg::R_DJX:  v = djx;
      jlvp_pkg::R_DJY:  v = djy;
      jlvp_pkg::R_SC:   v = sc;
      jlvp_pkg::R_AX:   v = ax;
      jlvp_pkg::R_AY:   v = ay;
      jlvp_pkg::R_VX:   v = vx;
      jlvp_pkg::R_VY:   v = vy;
      jlvp_pkg::R_VMAX: v = vmax;
      jlvp_pkg::R_AMAX: v = amax;
      jlvp_pkg::R_JMAX: v = jmax;
      jlvp_pkg::R_DT:   v = dt;
      default:          v = '0;
    endcase
    return v;
  endfunction

  logic signed [W-1:0] opa, opb, alu_res, diff_s, unit_res, wb_val;
  logic [W-1:0]        ma, mb;
  logic                single, fin, wb_en;
  jlvp_pkg::reg_sel_t  wb_dst;
  logic [QW-1:0]       mul_sh;
  logic [W:0]          rem_sh;
  logic [RW+3:0]       srem_sh, trial;

  always_comb begin
    opa = rd(cmd.a);
    opb = rd(cmd.b);
  end

  assign ma = opa[W-1] ? W'(-opa) : W'(opa);
  assign mb = opb[W-1] ? W'(-opb) : W'(opb);
  assign diff_s = satw1({opa[W-1], opa} - {opb[W-1], opb});
  assign single = cmd.op inside {jlvp_pkg::UO_SUB, jlvp_pkg::UO_SUBZ, jlvp_pkg::UO_ADD,
                                 jlvp_pkg::UO_HALF, jlvp_pkg::UO_MIN, jlvp_pkg::UO_SNAP,
                                 jlvp_pkg::UO_ZERO, jlvp_pkg::UO_MOV};

  always_comb begin
    case (cmd.op)
      jlvp_pkg::UO_SUB:  alu_res = diff_s;
      jlvp_pkg::UO_SUBZ: alu_res = diff_s[W-1] ? '0 : diff_s;
      jlvp_pkg::UO_ADD:  alu_res = satw1({opa[W-1], opa} + {opb[W-1], opb});
      jlvp_pkg::UO_HALF: alu_res = {1'b0, opa[W-1:1]};
      jlvp_pkg::UO_MIN:  alu_res = (opa > opb) ? opb : opa;
      jlvp_pkg::UO_SNAP: alu_res = (opa < TENTH && distance < HALF) ? '0 : opa;
      jlvp_pkg::UO_ZERO: alu_res = '0;
      default:           alu_res = opa;
    endcase
  end

  assign fin = run && (cnt == '0);
  assign mul_sh = prod >> F;
  assign rem_sh = {rem[W-1:0], dq[DW-1]};
  assign srem_sh = {srem, sacc[AW-1:AW-2]};
  assign trial = {2'b00, root, 2'b01};

  always_comb begin
    case (op_q)
      jlvp_pkg::UO_MUL:   unit_res = wsigned(mul_sh, neg_q);
      jlvp_pkg::UO_DIV:   unit_res = dz_q ? (sa_q ? WMIN : WMAX) : wsigned(QW'(dq), neg_q);
      jlvp_pkg::UO_SQRTH: unit_res = wsigned(QW'(root >> 1), 1'b0);
      default:            unit_res = wsigned(QW'(root), 1'b0);
    endcase
  end

  always_comb begin
    wb_en  = 1'b0;
    wb_dst = cmd.d;
    wb_val = alu_res;
    if (cmd.go && single) begin
      wb_en = 1'b1;
    end else if (fin && (op_q inside {jlvp_pkg::UO_MUL, jlvp_pkg::UO_DIV,
                                      jlvp_pkg::UO_SQRT, jlvp_pkg::UO_SQRTH})) begin
      wb_en  = 1'b1;
      wb_dst = d_q;
      wb_val = unit_res;
    end
  end

  // unit sequencing
  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= fin || (cmd.go && (single || cmd.op == jlvp_pkg::UO_PSHL ||
                                 cmd.op == jlvp_pkg::UO_CLR || cmd.op == jlvp_pkg::UO_OUT));
      if (fin) begin
        run <= 1'b0;
      end else if (run) begin
        cnt <= cnt - CW'(1);
      end else if (cmd.go) begin
        case (cmd.op)
          jlvp_pkg::UO_PSET, jlvp_pkg::UO_PADD, jlvp_pkg::UO_PDBL, jlvp_pkg::UO_MUL: begin
            run <= 1'b1;
            cnt <= CW'(W);
          end
          jlvp_pkg::UO_DIV: begin
            run <= 1'b1;
            cnt <= CW'(DW);
          end
          jlvp_pkg::UO_SQRT, jlvp_pkg::UO_SQRTH: begin
            run <= 1'b1;
            cnt <= CW'(RW);
          end
          default: run <= 1'b0;
        endcase
      end
    end
  end

  // unit data registers
  always_ff @(posedge clk) begin
    if (cmd.go && !run) begin
      op_q   <= cmd.op;
      d_q    <= cmd.d;
      neg_q  <= opa[W-1] ^ opb[W-1];
      sa_q   <= opa[W-1];
      dz_q   <= (opb == '0);
      mcand  <= QW'(ma);
      mplier <= mb;
      prod   <= '0;
      dq     <= {ma, {F{1'b0}}};
      dvs    <= mb;
      rem    <= '0;
      sacc   <= acc;
      root   <= '0;
      srem   <= '0;
    end else if (run && !fin) begin
      if (mplier[0]) begin
        prod <= prod + mcand;
      end
      mcand  <= mcand << 1;
      mplier <= mplier >> 1;
      if (rem_sh >= {1'b0, dvs}) begin
        rem <= rem_sh - {1'b0, dvs};
        dq  <= {dq[DW-2:0], 1'b1};
      end else begin
        rem <= rem_sh;
        dq  <= {dq[DW-2:0], 1'b0};
      end
      sacc <= sacc << 2;
      if (srem_sh >= trial) begin
        srem <= (RW+2)'(srem_sh - trial);
        root <= {root[RW-2:0], 1'b1};
      end else begin
        srem <= srem_sh[RW+1:0];
        root <= {root[RW-2:0], 1'b0};
      end
    end
  end

  // sum-of-squares accumulator
  always_ff @(posedge clk) begin
    if (cmd.go && cmd.op == jlvp_pkg::UO_PSHL) begin
      acc <= AW'(ma) << (F + 2);
    end else if (fin) begin
      case (op_q)
        jlvp_pkg::UO_PSET: acc <= AW'(prod);
        jlvp_pkg::UO_PADD: acc <= acc + AW'(prod);
        jlvp_pkg::UO_PDBL: acc <= AW'({prod, 1'b0});
        default:           acc <= acc;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_speed <= jlvp_pkg::SPEED_LIMIT_RST;
      cfg_accel <= jlvp_pkg::ACCEL_LIMIT_RST;
      cfg_jerk  <= jlvp_pkg::JERK_LIMIT_RST;
      cfg_dt    <= jlvp_pkg::STEP_TIME_RST;
    end else if (cfg_we) begin
      unique case (jlvp_pkg::cfg_idx_t'(cfg_index))
        jlvp_pkg::CFG_SPEED_LIMIT: cfg_speed <= cfg_data;
        jlvp_pkg::CFG_ACCEL_LIMIT: cfg_accel <= cfg_data;
        jlvp_pkg::CFG_JERK_LIMIT:  cfg_jerk  <= cfg_data;
        jlvp_pkg::CFG_STEP_TIME:   cfg_dt    <= cfg_data;
        default: ;
      endcase
    end
  end

  // working registers; velocity and acceleration are state and reset to zero
  always_ff @(posedge clk) begin
    if (rst) begin
      vx <= '0;
      vy <= '0;
      ax <= '0;
      ay <= '0;
    end else begin
      if (cmd.load) begin
        ox <= sat64(64'(in_x));
        oy <= sat64(64'(in_y));
      end
      if (cmd.go && cmd.op == jlvp_pkg::UO_CLR) begin
        vx        <= '0;
        vy        <= '0;
        ax        <= '0;
        ay        <= '0;
        out_vx    <= '0;
        out_vy    <= '0;
        out_speed <= '0;
      end
      if (cmd.go && cmd.op == jlvp_pkg::UO_OUT) begin
        out_vx    <= sat32(vx);
        out_vy    <= sat32(vy);
        out_speed <= (64'(t1) > 64'sd2147483647) ? 31'h7fffffff : 31'(t1);
      end
      if (wb_en) begin
        case (wb_dst)
          jlvp_pkg::R_OX:   ox       <= wb_val;
          jlvp_pkg::R_OY:   oy       <= wb_val;
          jlvp_pkg::R_DIST: distance <= wb_val;
          jlvp_pkg::R_T1:   t1       <= wb_val;
          jlvp_pkg::R_T2:   t2       <= wb_val;
          jlvp_pkg::R_SAFE: safe     <= wb_val;
          jlvp_pkg::R_TGT:  tgt      <= wb_val;
          jlvp_pkg::R_IVX:  ivx      <= wb_val;
          jlvp_pkg::R_IVY:  ivy      <= wb_val;
          jlvp_pkg::R_RX:   rx       <= wb_val;
          jlvp_pkg::R_RY:   ry       <= wb_val;
          jlvp_pkg::R_DJX:  djx      <= wb_val;
          jlvp_pkg::R_DJY:  djy      <= wb_val;
          jlvp_pkg::R_SC:   sc       <= wb_val;
          jlvp_pkg::R_AX:   ax       <= wb_val;
          jlvp_pkg::R_AY:   ay       <= wb_val;
          jlvp_pkg::R_VX:   vx       <= wb_val;
          jlvp_pkg::R_VY:   vy       <= wb_val;
          default: ;
        endcase
      end
    end
  end

  assign stat.done    = done;
  assign stat.safe_hi = safe > TWO;
  assign stat.dist_hi = distance > TENTH;
  assign stat.dj_hi   = t1 > t2;
  assign stat.am_hi   = t1 > amax;

endmodule

// ===== rtl/core/jlvp_ctrl.sv =====
// jlvp_ctrl: step sequencer walking the planner program and the stream handshake
// uses jlvp_pkg for the program, command and status types
module jlvp_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            s_tvalid,
  output logic            s_tready,
  input  logic            s_op,
  output logic            m_tvalid,
  input  logic            m_tready,
  output jlvp_pkg::cmd_t  cmd,
  input  jlvp_pkg::stat_t stat
);

  typedef enum logic [1:0] {S_IDLE, S_ISSUE, S_WAIT, S_OUT} state_t;

  state_t                     state;
  logic [jlvp_pkg::PC_W-1:0]  pc;
  logic                       clear_q;
  logic                       cond_ok;
  logic                       can_out;
  jlvp_pkg::uinstr_t          ui;

  assign ui = jlvp_pkg::ucode(pc);
  assign s_tready = (state == S_IDLE);
  assign can_out = !m_tvalid || m_tready;

  always_comb begin
    unique case (ui.cond)
      jlvp_pkg::C_ALL:     cond_ok = 1'b1;
      jlvp_pkg::C_SAFE_HI: cond_ok = stat.safe_hi;
      jlvp_pkg::C_SAFE_LO: cond_ok = !stat.safe_hi;
      jlvp_pkg::C_NEAR_HI: cond_ok = stat.dist_hi;
      jlvp_pkg::C_NEAR_LO: cond_ok = !stat.dist_hi;
      jlvp_pkg::C_DJ_HI:   cond_ok = stat.dj_hi;
      jlvp_pkg::C_DJ_LO:   cond_ok = !stat.dj_hi;
      jlvp_pkg::C_AM_HI:   cond_ok = stat.am_hi;
      default:             cond_ok = 1'b0;
    endcase
  end

  always_comb begin
    cmd.load = (state == S_IDLE) && s_tvalid;
    cmd.go   = 1'b0;
    cmd.op   = ui.op;
    cmd.a    = ui.a;
    cmd.b    = ui.b;
    cmd.d    = ui.d;
    if (state == S_ISSUE) begin
      cmd.go = cond_ok;
    end else if (state == S_OUT) begin
      cmd.go = can_out;
      cmd.op = clear_q ? jlvp_pkg::UO_CLR : jlvp_pkg::UO_OUT;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      pc       <= '0;
      clear_q  <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      // a new result replaces the one taken in the same cycle
      if (state == S_OUT && can_out) begin
        m_tvalid <= 1'b1;
      end else if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            clear_q <= s_op;
            pc      <= '0;
            state   <= s_op ? S_OUT : S_ISSUE;
          end
        end
        S_ISSUE: begin
          if (cond_ok) begin
            state <= S_WAIT;
          end else if (pc == jlvp_pkg::LAST_PC) begin
            state <= S_OUT;
          end else begin
            pc <= pc + 1'b1;
          end
        end
        S_WAIT: begin
          if (stat.done) begin
            if (pc == jlvp_pkg::LAST_PC) begin
              state <= S_OUT;
            end else begin
              pc    <= pc + 1'b1;
              state <= S_ISSUE;
            end
          end
        end
        S_OUT: begin
          if (can_out) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== rtl/core/jerk_limited_velocity_planner_2d_core.sv =====
// jerk_limited_velocity_planner_2d_core: top level of the 2d jerk-limited planner
// instantiates jlvp_ctrl and jlvp_dp; uses jlvp_pkg
//
// usage: each input word carries the offset to the target (tdata) and an
// operation flag (tuser: 0 plan a step, 1 clear velocity and acceleration).
// every input word yields exactly one output word with vel_x, vel_y and speed.
// one word is in flight at a time; s_tready is high only while idle.
// a plan step runs a 53-line program on one shared bit-serial multiplier,
// divider and square root; a line on a serial unit waits for that unit, an
// ALU line writes its result at issue and a skipped line only advances the
// program. the next word is taken only after the result is written, so no
// new word enters while a step runs. a clear skips the program and goes
// straight to the result write.
// the result sits in an output register; the next word is accepted while it
// waits, and the new result is only written once the old one is taken, so a
// stalled receiver stalls the block at its last step.
// the config channel is always ready; write it only while the block is idle.
// synchronous reset clears velocity and acceleration and restores the
// register defaults; no clearing pass is needed.
module jerk_limited_velocity_planner_2d_core #(
  parameter int FRAC_BITS = 16,
  parameter int WORD_BITS = 32
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               s_tvalid,
  output logic                               s_tready,
  input  logic [63:0]                        s_tdata,   // offset_x, offset_y
  input  logic                               s_tuser,   // op
  output logic                               m_tvalid,
  input  logic                               m_tready,
  output logic [95:0]                        m_tdata,   // vel_x, vel_y, speed, pad
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [jlvp_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [jlvp_pkg::CFG_W-1:0]         cfg_data
);

  jlvp_pkg::cmd_t   cmd;
  jlvp_pkg::stat_t  stat;
  logic signed [31:0] vel_x, vel_y;
  logic [30:0]        speed;

  assign cfg_ready = 1'b1;
  assign m_tdata = {1'b0, speed, vel_y, vel_x};

  jlvp_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_op     (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .cmd      (cmd),
    .stat     (stat)
  );

  jlvp_dp #(
    .FRAC_BITS (FRAC_BITS),
    .WORD_BITS (WORD_BITS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_x      (s_tdata[31:0]),
    .in_y      (s_tdata[63:32]),
    .cmd       (cmd),
    .stat      (stat),
    .out_vx    (vel_x),
    .out_vy    (vel_y),
    .out_speed (speed)
  );

`ifndef NO_ASSERTIONS
  // an accepted word leaves idle, so the input side closes right after acceptance
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("input still ready after accepting a word");

  // result write-out always raises the output valid
  a_out_raises_valid: assert property (@(posedge clk) disable iff (rst)
    cmd.go && (cmd.op == jlvp_pkg::UO_OUT || cmd.op == jlvp_pkg::UO_CLR) |=> m_tvalid)
    else $error("result written without output valid");

  // no program line is issued while a new word is being loaded
  a_no_go_on_load: assert property (@(posedge clk) disable iff (rst)
    cmd.load |-> !cmd.go)
    else $error("command issued during input load");
`endif

endmodule

// ===== verif/jerk_limited_velocity_planner_2d_core_test.sv =====
// jerk_limited_velocity_planner_2d_core_test: self-checking bench for the 2d jerk-limited planner;
// predicts each velocity word and compares it with dut output; needs jlvp_pkg and the core rtl
module jerk_limited_velocity_planner_2d_core_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam longint WMAX = 64'sd2147483647;
  localparam longint WMIN = -64'sd2147483648;
  localparam int FRAC = 16;
  localparam int STALL_LIMIT = 40000;

  typedef struct {
    logic signed [31:0] vel_x;
    logic signed [31:0] vel_y;
    logic [30:0]        speed;
  } vel_word_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [63:0] s_tdata = '0;
  logic s_tuser = 1'b0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [95:0] m_tdata;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [jlvp_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [jlvp_pkg::CFG_W-1:0] cfg_data = '0;

  // planner model state and registers
  longint vel_x_m, vel_y_m, acc_x_m, acc_y_m;
  longint vmax_m, amax_m, jmax_m, dt_m;

  vel_word_t pending_vel[$];
  int mismatches = 0;
  int words_checked = 0;
  int steps_sent = 0;
  int clears_sent = 0;
  int quiet_cycles = 0;
  bit no_idle = 1'b0;

  jerk_limited_velocity_planner_2d_core dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #4 clk = ~clk;

  function automatic longint clampw(longint v);
    return v > WMAX ? WMAX : (v < WMIN ? WMIN : v);
  endfunction

  function automatic logic [127:0] absw(longint v);
    logic [127:0] r;
    r = v < 0 ? 128'(-v) : 128'(v);
    return r;
  endfunction

  function automatic longint from_mag(logic [127:0] m, bit neg);
    logic [127:0] lim;
    lim = 128'(WMAX) + neg;
    if (m > lim) return neg ? WMIN : WMAX;
    return neg ? -longint'(m[63:0]) : longint'(m[63:0]);
  endfunction

  function automatic logic [127:0] isqrt(logic [127:0] n);
    logic [127:0] r, c;
    r = '0;
    for (int b = 63; b >= 0; b--) begin
      c = r | (128'd1 << b);
      if (c * c <= n) r = c;
    end
    return r;
  endfunction

  function automatic longint fx_mul(longint a, longint b);
    return from_mag((absw(a) * absw(b)) >> FRAC, (a < 0) != (b < 0));
  endfunction

  function automatic longint fx_div(longint a, longint b);
    if (b == 0) return a < 0 ? WMIN : WMAX;
    return from_mag((absw(a) << FRAC) / absw(b), (a < 0) != (b < 0));
  endfunction

  function automatic longint fx_mag(longint x, longint y);
    return from_mag(isqrt(absw(x) * absw(x) + absw(y) * absw(y)), 1'b0);
  endfunction

  // one planner step on the model state
  function automatic vel_word_t plan_velocity(bit clear, longint ox, longint oy);
    longint tenth, half, two, distance, lag, safe, target, ivx, ivy;
    longint rx, ry, djx, djy, djm, maxdj, sc, am, spd;
    vel_word_t w;
    tenth = ((64'sd1 << FRAC) + 5) / 10;
    half = 64'sd1 << (FRAC - 1);
    two = 64'sd1 << (FRAC + 1);
    ivx = 0;
    ivy = 0;
    if (clear) begin
      vel_x_m = 0; vel_y_m = 0; acc_x_m = 0; acc_y_m = 0;
      w.vel_x = '0; w.vel_y = '0; w.speed = '0;
      return w;
    end
    distance = fx_mag(ox, oy);
    lag = fx_mul(fx_mag(vel_x_m, vel_y_m), fx_div(amax_m, jmax_m)) >>> 1;
    safe = clampw(distance - lag);
    if (safe < 0) safe = 0;
    if (safe > two)
      target = from_mag(isqrt(2 * absw(amax_m) * absw(safe)), 1'b0);
    else
      target = fx_mul(from_mag(isqrt(absw(amax_m) * (128'd4 << FRAC)) >> 1, 1'b0), safe);
    if (target > vmax_m) target = vmax_m;
    if (target < tenth && distance < half) target = 0;
    if (distance > tenth) begin
      ivx = fx_mul(target, fx_div(ox, distance));
      ivy = fx_mul(target, fx_div(oy, distance));
    end
    rx = fx_div(clampw(ivx - vel_x_m), dt_m);
    ry = fx_div(clampw(ivy - vel_y_m), dt_m);
    djx = clampw(rx - acc_x_m);
    djy = clampw(ry - acc_y_m);
    djm = fx_mag(djx, djy);
    maxdj = fx_mul(jmax_m, dt_m);
    if (djm > maxdj) begin
      sc = fx_div(maxdj, djm);
      acc_x_m = clampw(acc_x_m + fx_mul(djx, sc));
      acc_y_m = clampw(acc_y_m + fx_mul(djy, sc));
    end else begin
      acc_x_m = rx;
      acc_y_m = ry;
    end
    am = fx_mag(acc_x_m, acc_y_m);
    if (am > amax_m) begin
      sc = fx_div(amax_m, am);
      acc_x_m = fx_mul(acc_x_m, sc);
      acc_y_m = fx_mul(acc_y_m, sc);
    end
    vel_x_m = clampw(vel_x_m + fx_mul(acc_x_m, dt_m));
    vel_y_m = clampw(vel_y_m + fx_mul(acc_y_m, dt_m));
    spd = fx_mag(vel_x_m, vel_y_m);
    w.vel_x = vel_x_m[31:0];
    w.vel_y = vel_y_m[31:0];
    w.speed = spd[30:0];
    return w;
  endfunction

  // model update, prediction and checking, all from values seen at the edge
  always @(posedge clk) begin
    vel_word_t got, want;
    if (rst) begin
      vel_x_m = 0; vel_y_m = 0; acc_x_m = 0; acc_y_m = 0;
      vmax_m = jlvp_pkg::SPEED_LIMIT_RST; amax_m = jlvp_pkg::ACCEL_LIMIT_RST;
      jmax_m = jlvp_pkg::JERK_LIMIT_RST; dt_m = jlvp_pkg::STEP_TIME_RST;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (jlvp_pkg::cfg_idx_t'(cfg_index))
          jlvp_pkg::CFG_SPEED_LIMIT: vmax_m = cfg_data;
          jlvp_pkg::CFG_ACCEL_LIMIT: amax_m = cfg_data;
          jlvp_pkg::CFG_JERK_LIMIT:  jmax_m = cfg_data;
          jlvp_pkg::CFG_STEP_TIME:   dt_m = cfg_data;
          default: ;
        endcase
      end
      if (s_tvalid && s_tready)
        pending_vel.push_back(plan_velocity(s_tuser, longint'($signed(s_tdata[31:0])),
                                            longint'($signed(s_tdata[63:32]))));
      if (m_tvalid && m_tready) begin
        got.vel_x = m_tdata[31:0];
        got.vel_y = m_tdata[63:32];
        got.speed = m_tdata[94:64];
        words_checked++;
        if (pending_vel.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected output word %h", m_tdata);
        end else begin
          want = pending_vel.pop_front();
          if (got.vel_x !== want.vel_x || got.vel_y !== want.vel_y ||
              got.speed !== want.speed) begin
            mismatches++;
            if (mismatches <= 10)
              $display("word %0d: expected vx=%0d vy=%0d spd=%0d, got vx=%0d vy=%0d spd=%0d",
                       words_checked, want.vel_x, want.vel_y, want.speed,
                       got.vel_x, got.vel_y, got.speed);
          end
        end
      end
    end
  end

  // receiver backpressure
  always @(posedge clk)
    m_tready <= no_idle || ($urandom_range(99) >= 29);

  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || rst)
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("watchdog: no handshake for %0d cycles", STALL_LIMIT);
      $display("Test completed with failures");
      $finish;
    end
  end

  task automatic send_word(bit op, logic [31:0] ox, logic [31:0] oy);
    while (!no_idle && $urandom_range(99) < 29) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser <= op;
    s_tdata <= {oy, ox};
    do @(posedge clk); while (!s_tready);
    if (op) clears_sent++; else steps_sent++;
  endtask

  task automatic wait_idle();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_vel.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(jlvp_pkg::cfg_idx_t idx, logic [30:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_limits(logic [30:0] vmax, logic [30:0] amax, logic [30:0] jmax,
                            logic [30:0] dt);
    write_reg(jlvp_pkg::CFG_SPEED_LIMIT, vmax);
    write_reg(jlvp_pkg::CFG_ACCEL_LIMIT, amax);
    write_reg(jlvp_pkg::CFG_JERK_LIMIT, jmax);
    write_reg(jlvp_pkg::CFG_STEP_TIME, dt);
  endtask

  task automatic test_directed_defaults();
    send_word(1'b0, 32'd0, 32'd0);
    send_word(1'b0, 32'h7fffffff, 32'h7fffffff);
    send_word(1'b0, 32'h80000000, 32'h80000000);
    send_word(1'b0, 32'h80000000, 32'h7fffffff);
    send_word(1'b1, 32'hffffffff, 32'hffffffff);
    send_word(1'b0, 32'd3276, 32'd0);          // inside the stop radius
    send_word(1'b0, 32'd6554, 32'd0);          // right at the stop radius
    send_word(1'b0, 32'd30000, 32'hffff0000);  // x below half a unit, y one unit back
    send_word(1'b0, 32'h00018000, 32'd0);      // ramp region
    send_word(1'b0, 32'h00020000, 32'd0);      // ramp boundary
    send_word(1'b0, 32'h00030000, 32'hfffd0000);
    for (int i = 0; i < 6; i++) send_word(1'b0, 32'h00640000, 32'hff9c0000);
    send_word(1'b0, 32'd0, 32'd1);
    send_word(1'b0, 32'hffffffff, 32'd0);
    send_word(1'b1, 32'd0, 32'd0);
    send_word(1'b0, 32'd0, 32'h80000000);
    wait_idle();
  endtask

  task automatic test_register_extremes();
    logic [30:0] top;
    top = 31'h7fffffff;
    set_limits(top, top, top, top);
    for (int i = 0; i < 4; i++) send_word(i == 3, $urandom, $urandom);
    wait_idle();
    set_limits(31'd1, 31'd1, 31'd1, 31'd1);
    for (int i = 0; i < 4; i++) send_word(1'b0, $urandom, $urandom);
    wait_idle();
    set_limits(top, 31'd1, top, 31'd1);
    for (int i = 0; i < 3; i++) send_word(1'b0, 32'h00100000, 32'h00050000);
    wait_idle();
    set_limits(31'd1, top, 31'd1, 31'd65536);
    for (int i = 0; i < 3; i++) send_word(1'b0, 32'hfff00000, 32'h00080000);
    send_word(1'b1, 32'd0, 32'd0);
    wait_idle();
  endtask

  // approach runs: the offset shrinks toward the target with random noise,
  // mixed with clears and full-range noise words
  task automatic test_random_approach(int words);
    int sent;
    longint ox, oy;
    int sh;
    sent = 0;
    while (sent < words) begin
      no_idle = (sent > words / 3 && sent < words / 2);
      case ($urandom_range(9))
        0: begin
          send_word(1'b1, $urandom, $urandom);
          sent++;
        end
        1, 2: begin
          send_word(1'b0, $urandom, $urandom);
          sent++;
        end
        default: begin
          sh = $urandom_range(30, 8);
          ox = longint'($signed(32'($urandom))) >>> (31 - sh);
          oy = longint'($signed(32'($urandom))) >>> (31 - sh);
          for (int k = $urandom_range(24, 6); k > 0 && sent < words; k--) begin
            send_word(1'b0, ox[31:0], oy[31:0]);
            sent++;
            ox = (ox * 3) / 4 + $signed($urandom_range(64)) - 32;
            oy = (oy * 3) / 4 + $signed($urandom_range(64)) - 32;
          end
        end
      endcase
    end
    no_idle = 1'b0;
    wait_idle();
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed_defaults();
    test_register_extremes();
    set_limits(jlvp_pkg::SPEED_LIMIT_RST, jlvp_pkg::ACCEL_LIMIT_RST,
               jlvp_pkg::JERK_LIMIT_RST, jlvp_pkg::STEP_TIME_RST);
    test_random_approach(250);
    set_limits(31'($urandom_range(32'h7fffffff, 1)), 31'($urandom_range(32'h3fffffff, 1)),
               31'($urandom_range(32'h7fffffff, 1)), 31'($urandom_range(4000, 1)));
    test_random_approach(150);
    set_limits(31'($urandom_range(32'h00ffffff, 65536)),
               31'($urandom_range(32'h0fffffff, 65536)),
               31'($urandom_range(32'h3fffffff, 65536)), 31'($urandom_range(2000, 16)));
    test_random_approach(150);
    set_limits(31'h7fffffff, 31'h7fffffff, 31'd1, 31'd1);
    test_random_approach(150);
    $display("covered %0d plan steps and %0d clears, %0d output words checked",
             steps_sent, clears_sent, words_checked);
    $display("register extremes, default limits and random limit sets were exercised");
    if (mismatches == 0 && pending_vel.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("%0d mismatches, %0d words never arrived", mismatches, pending_vel.size());
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
